// ===== design/swq_pkg.sv =====
// Shared types and constants for the semaphore wait-queue table.
// No dependencies.
`timescale 1ns / 1ps
package swq_pkg;
  localparam int NUM_ENTRIES = 32;
  localparam int NUM_PROCS   = 32;
  localparam int DW = $clog2(NUM_ENTRIES);
  localparam int PW = 5;
  localparam int KW = 31;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_BLOCK   = 2'd0,
    CMD_UNBLOCK = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_NOFREE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PWK, S_SCAN, S_SCANW, S_ACT, S_WALK, S_WALKW, S_DONE
  } fsm_t;

  // Descriptor word: key, head, tail.
  typedef struct packed {
    logic [KW-1:0] key;
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } desc_t;

  // Process word: link (msb set means end of queue) and wait key.
  typedef struct packed {
    logic [PW:0]   nxt;
    logic [KW-1:0] wkey;
  } proc_t;
endpackage

// ===== design/swq_desc_mem.sv =====
// Descriptor store: one-port synchronous RAM plus active bits.
// Depends on swq_pkg.
`timescale 1ns / 1ps
module swq_desc_mem
  import swq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [DW-1:0]          addr,
  input  logic                   we,
  input  desc_t                  wdata,
  input  logic                   act_we,
  input  logic                   act_val,
  output desc_t                  rdata,
  output logic [NUM_ENTRIES-1:0] active
);
  desc_t mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] active_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (act_we) begin
      active_r[addr] <= act_val;
    end
  end

  assign active = active_r;
endmodule

// ===== design/swq_proc_mem.sv =====
// Process store: link and wait key per process, with valid bits so that
// wait keys read as zero after reset. Depends on swq_pkg.
`timescale 1ns / 1ps
module swq_proc_mem
  import swq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [PW-1:0] addr,
  input  logic          we,
  input  proc_t         wdata,
  output proc_t         rdata
);
  proc_t mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] vld_r;
  proc_t raw_r;
  logic  rv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    raw_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      rv_r <= vld_r[addr];
      if (we) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  assign rdata = rv_r ? raw_r : proc_t'{nxt: raw_r.nxt, wkey: '0};
endmodule

// ===== design/swq_ctrl.sv =====
// Command sequencer: scans descriptors, walks wait queues, writes back.
// Depends on swq_pkg.
`timescale 1ns / 1ps
module swq_ctrl
  import swq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_command,
  input  logic [KW-1:0]          in_sem_key,
  input  logic [PW-1:0]          in_proc_id,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [PW-1:0]          out_result_proc,
  output logic [DW-1:0]          d_addr,
  output logic                   d_we,
  output desc_t                  d_wdata,
  output logic                   d_act_we,
  output logic                   d_act_val,
  input  desc_t                  d_rdata,
  input  logic [NUM_ENTRIES-1:0] d_active,
  output logic [PW-1:0]          p_addr,
  output logic                   p_we,
  output proc_t                  p_wdata,
  input  proc_t                  p_rdata
);
  fsm_t st_r, st_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [PW-1:0] pid_r, pid_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [DW-1:0] hit_r, hit_nxt;
  logic          free_ok_r, free_ok_nxt;
  logic [DW-1:0] free_r, free_nxt;
  desc_t         dsc_r, dsc_nxt;
  logic [PW:0]   prev_r, prev_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [1:0]    wb_r, wb_nxt;
  logic          ov_r, ov_nxt;
  logic [DW-1:0] idx_a;

  assign idx_a = idx_r[DW-1:0];
  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = stat_r;
  assign out_result_proc = rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; key_r <= key_nxt; pid_r <= pid_nxt; idx_r <= idx_nxt;
    found_r <= found_nxt; hit_r <= hit_nxt; free_ok_r <= free_ok_nxt;
    free_r <= free_nxt; dsc_r <= dsc_nxt; prev_r <= prev_nxt; cur_r <= cur_nxt;
    stat_r <= stat_nxt; rp_r <= rp_nxt; wb_r <= wb_nxt;
  end

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; key_nxt = key_r; pid_nxt = pid_r;
    idx_nxt = idx_r; found_nxt = found_r; hit_nxt = hit_r;
    free_ok_nxt = free_ok_r; free_nxt = free_r; dsc_nxt = dsc_r;
    prev_nxt = prev_r; cur_nxt = cur_r; stat_nxt = stat_r; rp_nxt = rp_r;
    wb_nxt = wb_r; ov_nxt = 1'b0;
    d_addr = idx_a; d_we = 1'b0; d_wdata = dsc_r; d_act_we = 1'b0;
    d_act_val = 1'b0;
    p_addr = pid_r; p_we = 1'b0; p_wdata = '0;
    case (st_r)
      S_IDLE: begin
        p_addr = in_proc_id;
        if (start) begin
          cmd_nxt = in_command; key_nxt = in_sem_key; pid_nxt = in_proc_id;
          stat_nxt = ST_NONE; rp_nxt = '0; found_nxt = 1'b0;
          free_ok_nxt = 1'b0; idx_nxt = '0;
          st_nxt = S_PWK;
        end
      end
      S_PWK: begin
        // wait key of pid is on p_rdata now
        if (cmd_r == CMD_BLOCK && (key_r == '0 || p_rdata.wkey != '0)) begin
          st_nxt = S_DONE;
        end else if (cmd_r == CMD_REMOVE) begin
          if (p_rdata.wkey == '0) begin
            st_nxt = S_DONE;
          end else begin
            key_nxt = p_rdata.wkey;
            st_nxt = S_SCAN;
          end
        end else begin
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // one free descriptor per cycle, an active one also waits in S_SCANW; stop at first active match
        if (d_active[idx_a] && !found_r) begin
          d_addr = idx_a;
        end
        if (!d_active[idx_a] && !free_ok_r) begin
          free_ok_nxt = 1'b1; free_nxt = idx_a;
        end
        if (d_active[idx_a]) begin
          hit_nxt = idx_a;
          st_nxt = S_SCANW;
        end else if (idx_r == CW'(NUM_ENTRIES - 1)) begin
          st_nxt = S_ACT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCANW: begin
        if (d_rdata.key == key_r) begin
          found_nxt = 1'b1; dsc_nxt = d_rdata;
          st_nxt = S_ACT;
        end else if (idx_r == CW'(NUM_ENTRIES - 1)) begin
          st_nxt = S_ACT;
        end else begin
          idx_nxt = idx_r + 1'b1;
          st_nxt = S_SCAN;
        end
      end
      S_ACT: begin
        st_nxt = S_DONE;
        d_addr = hit_r;
        case (cmd_r)
          CMD_BLOCK: begin
            if (found_r) begin
              // link old tail to pid, pid becomes tail
              p_addr = dsc_r.tail; p_we = 1'b1;
              p_wdata = '{nxt: {1'b0, pid_r}, wkey: key_r};
              d_we = 1'b1; d_wdata = '{key: dsc_r.key, head: dsc_r.head,
                                       tail: pid_r};
              cur_nxt = pid_r; st_nxt = S_WALKW; wb_nxt = 2'd0;
              stat_nxt = ST_OK;
              // tail wait key must be preserved: patch in S_WALKW via reread
              p_we = 1'b0; cur_nxt = dsc_r.tail; p_addr = dsc_r.tail;
              wb_nxt = 2'd1;
            end else if (free_ok_r) begin
              d_addr = free_r; d_we = 1'b1;
              d_wdata = '{key: key_r, head: pid_r, tail: pid_r};
              d_act_we = 1'b1; d_act_val = 1'b1;
              p_we = 1'b1;
              p_wdata = '{nxt: {1'b1, {PW{1'b0}}}, wkey: key_r};
              stat_nxt = ST_OK;
            end else begin
              stat_nxt = ST_NOFREE;
            end
          end
          CMD_PEEK: begin
            if (found_r) begin
              stat_nxt = ST_OK; rp_nxt = dsc_r.head;
            end
          end
          default: begin
            // unblock head or remove pid: walk from head
            if (found_r) begin
              prev_nxt = {1'b1, {PW{1'b0}}};
              cur_nxt = dsc_r.head; p_addr = dsc_r.head;
              wb_nxt = 2'd2; st_nxt = S_WALKW;
            end
          end
        endcase
      end
      S_WALKW: begin
        p_addr = cur_r;
        if (wb_r == 2'd1) begin
          // append: old tail -> pid, then pid as last
          p_we = 1'b1; p_wdata = '{nxt: {1'b0, pid_r}, wkey: p_rdata.wkey};
          st_nxt = S_WALK; wb_nxt = 2'd3;
        end else begin
          st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        p_addr = cur_r;
        if (wb_r == 2'd3) begin
          p_addr = pid_r; p_we = 1'b1;
          p_wdata = '{nxt: {1'b1, {PW{1'b0}}}, wkey: key_r};
          st_nxt = S_DONE;
        end else if (cmd_r == CMD_UNBLOCK || cur_r == pid_r) begin
          // unlink cur_r; p_rdata holds its link
          p_we = 1'b1; p_wdata = '{nxt: p_rdata.nxt, wkey: '0};
          stat_nxt = ST_OK; rp_nxt = cur_r;
          st_nxt = S_DONE;
          if (prev_r[PW]) begin
            d_addr = hit_r;
            if (p_rdata.nxt[PW]) begin
              d_act_we = 1'b1; d_act_val = 1'b0;
            end else begin
              d_we = 1'b1;
              d_wdata = '{key: dsc_r.key, head: p_rdata.nxt[PW-1:0],
                          tail: dsc_r.tail};
            end
          end else begin
            // fix predecessor link after rereading it in S_WALKW; hold the removed link in prev
            prev_nxt = p_rdata.nxt;
            st_nxt = S_WALKW; wb_nxt = 2'd0;
            cur_nxt = prev_r[PW-1:0];
            cmd_nxt = CMD_PEEK; // marks predecessor patch
          end
        end else if (p_rdata.nxt[PW]) begin
          st_nxt = S_DONE;
        end else begin
          prev_nxt = {1'b0, cur_r};
          cur_nxt = p_rdata.nxt[PW-1:0];
          st_nxt = S_WALKW;
        end
        if (cmd_r == CMD_PEEK && wb_r == 2'd0) begin
          // predecessor patch: rewrite its link, maybe the tail
          p_addr = cur_r; p_we = 1'b1;
          p_wdata = '{nxt: prev_r, wkey: p_rdata.wkey};
          d_we = prev_r[PW]; d_addr = hit_r;
          d_wdata = '{key: dsc_r.key, head: dsc_r.head, tail: cur_r};
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== design/semaphore_wait_queue_table_top.sv =====
// Semaphore wait-queue table top level.
// Depends on swq_pkg, swq_desc_mem, swq_proc_mem, swq_ctrl.
//
// Usage: drive in_command, in_sem_key and in_proc_id and raise start while
// busy is low; the command is taken at that edge. Exactly one result word
// follows, shown for one cycle with out_valid high on out_status and
// out_result_proc. The receiver cannot stall; nothing holds the result.
// A command rejected at the wait-key check (block with key 0 or on an already
// blocked process, remove of a process that waits on nothing) passes only the
// wait-key read and done states. Otherwise the descriptor scan visits S_SCAN
// for each free entry and S_SCAN and S_SCANW for each active entry, between
// the wait-key read and the action and done states. Appending to an existing
// queue adds S_WALKW and S_WALK; commands 1 and 2 add both per waiter visited,
// and both again when a predecessor link is patched. out_valid is high in the
// cycle after the last busy cycle, the first cycle a new command can be taken.
// Reset (synchronous, rst_n low) frees all descriptors and marks all
// processes not blocked at once; no clearing pass is needed.
`timescale 1ns / 1ps
module semaphore_wait_queue_table_top
  import swq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_command,
  input  logic [KW-1:0] in_sem_key,
  input  logic [PW-1:0] in_proc_id,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [PW-1:0] out_result_proc
);
  logic [DW-1:0] d_addr;
  logic d_we, d_act_we, d_act_val, p_we;
  desc_t d_wdata, d_rdata;
  logic [NUM_ENTRIES-1:0] d_active;
  logic [PW-1:0] p_addr;
  proc_t p_wdata, p_rdata;

  swq_desc_mem u_desc (
    .clk, .rst_n, .addr(d_addr), .we(d_we), .wdata(d_wdata),
    .act_we(d_act_we), .act_val(d_act_val), .rdata(d_rdata), .active(d_active)
  );

  swq_proc_mem u_proc (
    .clk, .rst_n, .addr(p_addr), .we(p_we), .wdata(p_wdata), .rdata(p_rdata)
  );

  swq_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_command, .in_sem_key, .in_proc_id,
    .out_valid, .out_status, .out_result_proc,
    .d_addr, .d_we, .d_wdata, .d_act_we, .d_act_val, .d_rdata, .d_active,
    .p_addr, .p_we, .p_wdata, .p_rdata
  );
endmodule

// ===== design/swq_checker.sv =====
// Port-level checks for the semaphore wait-queue table, bound to the top.
// Depends on swq_pkg.
`timescale 1ns / 1ps
module swq_checker
  import swq_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input logic [1:0]    out_status,
  input logic [PW-1:0] out_result_proc
);
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NONE ||
                   out_status == ST_NOFREE)) else $error("bad status");
  a_rp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_result_proc == '0)
    else $error("result proc set without ok");
endmodule

bind semaphore_wait_queue_table_top swq_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_result_proc
);

// ===== tb/semaphore_wait_queue_table_checker.sv =====
// Checker for the semaphore wait-queue table: predicts each result word from
// accepted commands and compares it with the strobed output. Depends on swq_pkg.
`timescale 1ns / 1ps
module semaphore_wait_queue_table_checker
  import swq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  logic [1:0]    in_command,
  input  logic [KW-1:0] in_sem_key,
  input  logic [PW-1:0] in_proc_id,
  input  logic          out_valid,
  input  logic [1:0]    out_status,
  input  logic [PW-1:0] out_result_proc,
  output int            fail_count,
  output int            pending,
  output int            words_seen,
  output int            full_seen
);
  typedef struct {
    status_t       st;
    logic [PW-1:0] rp;
  } word_t;

  logic          sem_used [NUM_ENTRIES];
  logic [KW-1:0] sem_key_of [NUM_ENTRIES];
  logic [PW-1:0] sem_first [NUM_ENTRIES];
  logic [PW-1:0] sem_last [NUM_ENTRIES];
  logic [PW:0]   link_of [NUM_PROCS];
  logic [KW-1:0] waits_on [NUM_PROCS];
  word_t         expected_words[$];

  function automatic int lookup(logic [KW-1:0] k);
    for (int i = 0; i < NUM_ENTRIES; i++)
      if (sem_used[i] && sem_key_of[i] == k) return i;
    return -1;
  endfunction

  task automatic clear_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sem_used[i] = 0; sem_key_of[i] = '0; sem_first[i] = '0; sem_last[i] = '0;
    end
    for (int i = 0; i < NUM_PROCS; i++) begin
      link_of[i] = '0; waits_on[i] = '0;
    end
  endtask

  function automatic word_t apply_command(cmd_t c, logic [KW-1:0] k, logic [PW-1:0] p);
    word_t w;
    int d;
    logic [PW:0] prev, cur, nx;
    w.st = ST_NONE;
    w.rp = '0;
    case (c)
      CMD_BLOCK: begin
        if (k != 0 && waits_on[p] == 0) begin
          d = lookup(k);
          link_of[p] = 6'd32;
          if (d >= 0) begin
            link_of[sem_last[d]] = {1'b0, p};
            sem_last[d] = p;
            waits_on[p] = k;
            w.st = ST_OK;
          end else begin
            w.st = ST_NOFREE;
            for (int i = 0; i < NUM_ENTRIES; i++)
              if (!sem_used[i]) begin
                sem_used[i] = 1; sem_key_of[i] = k;
                sem_first[i] = p; sem_last[i] = p;
                waits_on[p] = k;
                w.st = ST_OK;
                break;
              end
          end
        end
      end
      CMD_UNBLOCK: begin
        d = lookup(k);
        if (d >= 0) begin
          w.rp = sem_first[d];
          if (link_of[w.rp][PW]) sem_used[d] = 0;
          else sem_first[d] = link_of[w.rp][PW-1:0];
          waits_on[w.rp] = '0;
          w.st = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (waits_on[p] != 0) begin
          d = lookup(waits_on[p]);
          if (d >= 0) begin
            prev = 6'd32;
            cur = {1'b0, sem_first[d]};
            for (int n = 0; n < NUM_PROCS && !cur[PW]; n++) begin
              nx = link_of[cur[PW-1:0]];
              if (cur[PW-1:0] == p) begin
                if (prev[PW]) begin
                  if (nx[PW]) sem_used[d] = 0;
                  else sem_first[d] = nx[PW-1:0];
                end else begin
                  link_of[prev[PW-1:0]] = nx;
                  if (nx[PW]) sem_last[d] = prev[PW-1:0];
                end
                waits_on[p] = '0;
                w.rp = p;
                w.st = ST_OK;
                break;
              end
              prev = cur;
              cur = nx;
            end
          end
        end
      end
      default: begin
        d = lookup(k);
        if (d >= 0) begin
          w.rp = sem_first[d];
          w.st = ST_OK;
        end
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    word_t w;
    int errs;
    errs = 0;
    if (!rst_n) begin
      clear_table();
      expected_words.delete();
      fail_count <= 0;
      words_seen <= 0;
      full_seen <= 0;
    end else begin
      // compare before queuing, the block cannot answer in the accepting cycle
      if (out_valid) begin
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: status %0d proc %0d",
                 out_status, out_result_proc);
          errs++;
        end else begin
          w = expected_words.pop_front();
          if (out_status !== w.st) begin
            $error("status: expected %0d actual %0d", w.st, out_status);
            errs++;
          end
          if (out_result_proc !== w.rp) begin
            $error("result_proc: expected %0d actual %0d", w.rp, out_result_proc);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (start && !busy) begin
        w = apply_command(cmd_t'(in_command), in_sem_key, in_proc_id);
        if (w.st == ST_NOFREE) full_seen <= full_seen + 1;
        expected_words.push_back(w);
      end
    end
    pending = expected_words.size();
  end
endmodule

// ===== tb/semaphore_wait_queue_table_top_tb.sv =====
// Testbench top for the semaphore wait-queue table: drives commands in bursts,
// then gives the verdict. Depends on swq_pkg, the block and the checker.
`timescale 1ns / 1ps
module semaphore_wait_queue_table_top_tb;
  import swq_pkg::*;

  localparam int RANDOM_WORDS = 700;
  localparam int CYCLE_LIMIT  = 400000;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          start = 0;
  logic          busy;
  logic [1:0]    in_command = CMD_PEEK;
  logic [KW-1:0] in_sem_key = '0;
  logic [PW-1:0] in_proc_id = '0;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [PW-1:0] out_result_proc;
  int            fail_count, pending, words_seen, full_seen;
  int            cycles = 0;
  int            sent = 0;
  logic [KW-1:0] key_pool [8];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  semaphore_wait_queue_table_top dut (.*);
  semaphore_wait_queue_table_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // hold the word until the block takes it, then drop start for a cycle
  task automatic send_word(cmd_t c, logic [KW-1:0] k, logic [PW-1:0] p);
    start <= 1'b1;
    in_command <= c;
    in_sem_key <= k;
    in_proc_id <= p;
    do @(posedge clk); while (busy);
    sent++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [KW-1:0] pick_key(int mode);
    if (mode < 6) return key_pool[$urandom_range(0, 7)];
    if (mode < 8) return KW'($urandom_range(1, 40));
    return KW'($urandom);
  endfunction

  initial begin
    int burst, mode, r;
    cmd_t c;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: key extremes, key zero, double block, remove of idle process
    send_word(CMD_BLOCK, 31'h7fffffff, 5'd31);
    send_word(CMD_BLOCK, 31'd1, 5'd0);
    send_word(CMD_BLOCK, 31'd0, 5'd3);
    send_word(CMD_BLOCK, 31'd1, 5'd0);
    send_word(CMD_BLOCK, 31'd1, 5'd7);
    send_word(CMD_PEEK, 31'h7fffffff, 5'd0);
    send_word(CMD_PEEK, 31'd0, 5'd0);
    send_word(CMD_UNBLOCK, 31'd1, 5'd0);
    send_word(CMD_REMOVE, 31'd4, 5'd4);
    send_word(CMD_REMOVE, 31'd0, 5'd31);
    send_word(CMD_UNBLOCK, 31'd0, 5'd0);
    send_word(CMD_UNBLOCK, 31'd1, 5'd0);
    send_word(CMD_UNBLOCK, 31'd1, 5'd0);
    send_word(CMD_PEEK, 31'h2aaaaaaa, 5'd21);
    // one waiter per key on NUM_PROCS - 1 keys, then one more key fills the pool
    for (int i = 0; i < NUM_PROCS - 1; i++)
      send_word(CMD_BLOCK, KW'(32'h1000 + i), i[PW-1:0]);
    send_word(CMD_BLOCK, 31'h5555, 5'd31);
    for (int i = 0; i < NUM_PROCS; i++)
      send_word(CMD_REMOVE, '0, i[PW-1:0]);

    for (int i = 0; i < 8; i++)
      key_pool[i] = (i == 0) ? 31'h7fffffff : KW'($urandom_range(1, 32'h7ffffffe));

    // random: mostly block/unblock on a small key pool so queues grow deep
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        c = r < 45 ? CMD_BLOCK : r < 65 ? CMD_UNBLOCK : r < 85 ? CMD_REMOVE : CMD_PEEK;
        mode = $urandom_range(0, 9);
        send_word(c, ($urandom_range(0, 60) == 0) ? '0 : pick_key(mode),
                  PW'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 80));
    end

    while (pending != 0) @(posedge clk);
    idle_gap(100);
    $display("Sent %0d commands, checked %0d result words, %0d pool-full answers.",
             sent, words_seen, full_seen);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
